@@ rtl/core/assert_macros.svh @@
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, muted during reset
`define AST_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, muted during reset
`define AST_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

// Next-cycle implication that also holds across reset
`define AST_NEXT_ALWAYS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ rtl/core/alist_pkg.sv @@
// Shared constants, codes and types of the array list engine
`timescale 1ns / 1ps

package alist_pkg;

  localparam int DEPTH       = 256;
  localparam int ADDR_W      = $clog2(DEPTH);
  localparam int FILL_W      = $clog2(DEPTH + 1);
  localparam int KIND_W      = 3;
  localparam int POS_W       = 16;
  localparam int WORD_W      = 32;
  localparam int STATUS_W    = 2;
  localparam int OP_W        = 3;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef logic [KIND_W-1:0]   kind_t;
  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [OP_W-1:0]     op_t;
  typedef logic [ADDR_W-1:0]   addr_t;
  typedef logic [FILL_W-1:0]   fill_t;
  typedef logic [WORD_W-1:0]   word_t;

  localparam kind_t KIND_PUSH   = 3'd0;
  localparam kind_t KIND_INSERT = 3'd1;
  localparam kind_t KIND_REMOVE = 3'd2;
  localparam kind_t KIND_SET    = 3'd3;
  localparam kind_t KIND_GET    = 3'd4;
  localparam kind_t KIND_CLEAR  = 3'd5;

  localparam status_t ST_DONE  = 2'd0;
  localparam status_t ST_FULL  = 2'd1;
  localparam status_t ST_RANGE = 2'd2;

  // Work codes handed from the front end to the back end
  localparam op_t OP_NOP    = 3'd0;
  localparam op_t OP_WRITE  = 3'd1;
  localparam op_t OP_READ   = 3'd2;
  localparam op_t OP_INSERT = 3'd3;
  localparam op_t OP_REMOVE = 3'd4;

  typedef struct packed {
    op_t     op;
    addr_t   addr;    // target entry
    addr_t   src;     // first source entry of a shift
    fill_t   moves;   // entries to shift
    word_t   word;
    fill_t   count;   // length after the request
    status_t status;
  } job_t;

endpackage

@@ rtl/core/alist_if.sv @@
// Request and result channel interfaces
`timescale 1ns / 1ps

interface alist_req_if;
  logic                                valid;
  logic                                ready;
  logic [alist_pkg::KIND_W-1:0]        kind;
  logic signed [alist_pkg::POS_W-1:0]  position;
  logic signed [alist_pkg::WORD_W-1:0] word_in;

  modport source (output valid, kind, position, word_in, input ready);
  modport sink   (input valid, kind, position, word_in, output ready);
endinterface

interface alist_rsp_if;
  logic                                valid;
  logic                                ready;
  logic signed [alist_pkg::WORD_W-1:0] word_out;
  logic [alist_pkg::FILL_W-1:0]        count;
  logic [alist_pkg::STATUS_W-1:0]      status;

  modport source (output valid, word_out, count, status, input ready);
  modport sink   (input valid, word_out, count, status, output ready);
endinterface

@@ rtl/core/alist_ram.sv @@
// Generic simple dual-port RAM, one write and one registered read port
`timescale 1ns / 1ps

module alist_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/core/alist_front.sv @@
// Front end: takes requests, tracks the length and classifies each request
`timescale 1ns / 1ps

module alist_front (
  input  logic              clk,
  input  logic              rst_n,
  alist_req_if.sink         in_req,
  input  logic              q_full,
  output logic              q_push,
  output alist_pkg::job_t   q_job
);

  alist_pkg::fill_t fill_r, fill_nxt;

  logic [alist_pkg::POS_W-1:0] pos_u;
  logic [alist_pkg::POS_W-1:0] fill_wide;
  logic                        pos_neg;
  logic                        in_range;
  logic                        full;
  alist_pkg::fill_t            fill_inc;
  alist_pkg::fill_t            fill_dec;
  alist_pkg::fill_t            ins_at;
  alist_pkg::fill_t            pos_fill;

  assign in_req.ready = !q_full;
  assign q_push       = in_req.valid && !q_full;

  always_comb begin
    pos_u     = $unsigned(in_req.position);
    pos_neg   = in_req.position[alist_pkg::POS_W-1];
    fill_wide = alist_pkg::POS_W'(fill_r);
    pos_fill  = pos_u[alist_pkg::FILL_W-1:0];
    in_range  = !pos_neg && (pos_u < fill_wide);
    full      = (fill_r == alist_pkg::FILL_W'(alist_pkg::DEPTH));
    fill_inc  = fill_r + alist_pkg::FILL_W'(1);
    fill_dec  = fill_r - alist_pkg::FILL_W'(1);

    // insert position clamped to 0..length
    if (pos_neg) begin
      ins_at = '0;
    end else if (pos_u > fill_wide) begin
      ins_at = fill_r;
    end else begin
      ins_at = pos_fill;
    end

    fill_nxt     = fill_r;
    q_job.op     = alist_pkg::OP_NOP;
    q_job.addr   = '0;
    q_job.src    = '0;
    q_job.moves  = '0;
    q_job.word   = $unsigned(in_req.word_in);
    q_job.status = alist_pkg::ST_DONE;

    unique case (in_req.kind)
      alist_pkg::KIND_PUSH: begin
        if (full) begin
          q_job.status = alist_pkg::ST_FULL;
        end else begin
          q_job.op   = alist_pkg::OP_WRITE;
          q_job.addr = fill_r[alist_pkg::ADDR_W-1:0];
          fill_nxt   = fill_inc;
        end
      end
      alist_pkg::KIND_INSERT: begin
        if (full) begin
          q_job.status = alist_pkg::ST_FULL;
        end else begin
          q_job.op    = alist_pkg::OP_INSERT;
          q_job.addr  = ins_at[alist_pkg::ADDR_W-1:0];
          q_job.src   = fill_dec[alist_pkg::ADDR_W-1:0];
          q_job.moves = fill_r - ins_at;
          fill_nxt    = fill_inc;
        end
      end
      alist_pkg::KIND_REMOVE: begin
        if (!in_range) begin
          q_job.status = alist_pkg::ST_RANGE;
        end else begin
          q_job.op    = alist_pkg::OP_REMOVE;
          q_job.addr  = pos_u[alist_pkg::ADDR_W-1:0];
          q_job.src   = pos_u[alist_pkg::ADDR_W-1:0] + alist_pkg::ADDR_W'(1);
          q_job.moves = fill_dec - pos_fill;
          fill_nxt    = fill_dec;
        end
      end
      alist_pkg::KIND_SET: begin
        if (!in_range) begin
          q_job.status = alist_pkg::ST_RANGE;
        end else begin
          q_job.op   = alist_pkg::OP_WRITE;
          q_job.addr = pos_u[alist_pkg::ADDR_W-1:0];
        end
      end
      alist_pkg::KIND_GET: begin
        if (!in_range) begin
          q_job.status = alist_pkg::ST_RANGE;
        end else begin
          q_job.op   = alist_pkg::OP_READ;
          q_job.addr = pos_u[alist_pkg::ADDR_W-1:0];
        end
      end
      alist_pkg::KIND_CLEAR: begin
        fill_nxt = '0;
      end
      default: begin
      end
    endcase

    q_job.count = fill_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (q_push) begin
      fill_r <= fill_nxt;
    end
  end

endmodule

@@ rtl/core/alist_queue.sv @@
// Short job queue between the front end and the back end
`timescale 1ns / 1ps

module alist_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  alist_pkg::job_t  push_job,
  output logic             full,
  input  logic             pop,
  output logic             empty,
  output alist_pkg::job_t  head
);

  alist_pkg::job_t                slots_r [alist_pkg::QUEUE_DEPTH];
  logic [alist_pkg::QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [alist_pkg::QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [alist_pkg::QCNT_W-1:0]   cnt_r, cnt_nxt;

  localparam logic [alist_pkg::QPTR_W-1:0] PTR_LAST =
    alist_pkg::QPTR_W'(alist_pkg::QUEUE_DEPTH - 1);

  assign full  = (cnt_r == alist_pkg::QCNT_W'(alist_pkg::QUEUE_DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = slots_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + alist_pkg::QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + alist_pkg::QPTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + alist_pkg::QCNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - alist_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

@@ rtl/core/alist_back.sv @@
// Back end: runs each job against the entry RAM and drives the result register
`timescale 1ns / 1ps

module alist_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_empty,
  input  alist_pkg::job_t  q_head,
  output logic             q_pop,
  alist_rsp_if.source      out_rsp
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_WRITE = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_RDATA = 3'd3;
  localparam logic [2:0] S_SHIFT = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]          state_r, state_nxt;
  alist_pkg::op_t      op_r, op_nxt;
  alist_pkg::addr_t    addr_r, addr_nxt;
  alist_pkg::addr_t    rd_addr_r, rd_addr_nxt;
  alist_pkg::addr_t    wr_addr_r, wr_addr_nxt;
  alist_pkg::fill_t    cnt_r, cnt_nxt;
  logic                pend_r, pend_nxt;
  alist_pkg::word_t    word_r, word_nxt;
  alist_pkg::fill_t    count_r, count_nxt;
  alist_pkg::status_t  status_r, status_nxt;
  alist_pkg::word_t    rd_word_r, rd_word_nxt;
  logic                out_valid_r, out_valid_nxt;
  alist_pkg::word_t    out_word_r, out_word_nxt;
  alist_pkg::fill_t    out_count_r, out_count_nxt;
  alist_pkg::status_t  out_status_r, out_status_nxt;

  logic             ram_we;
  alist_pkg::addr_t ram_waddr;
  alist_pkg::word_t ram_wdata;
  logic             ram_re;
  alist_pkg::addr_t ram_raddr;
  alist_pkg::word_t ram_rdata;
  logic             out_free;
  logic             is_insert;

  alist_ram #(
    .WIDTH (alist_pkg::WORD_W),
    .DEPTH (alist_pkg::DEPTH)
  ) u_entries (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_free  = !out_valid_r || out_rsp.ready;
  assign is_insert = (op_r == alist_pkg::OP_INSERT);

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    addr_nxt       = addr_r;
    rd_addr_nxt    = rd_addr_r;
    wr_addr_nxt    = wr_addr_r;
    cnt_nxt        = cnt_r;
    pend_nxt       = pend_r;
    word_nxt       = word_r;
    count_nxt      = count_r;
    status_nxt     = status_r;
    rd_word_nxt    = rd_word_r;
    out_valid_nxt  = out_valid_r && !out_rsp.ready;
    out_word_nxt   = out_word_r;
    out_count_nxt  = out_count_r;
    out_status_nxt = out_status_r;
    q_pop          = 1'b0;
    ram_we         = 1'b0;
    ram_waddr      = addr_r;
    ram_wdata      = word_r;
    ram_re         = 1'b0;
    ram_raddr      = addr_r;

    unique case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          q_pop       = 1'b1;
          op_nxt      = q_head.op;
          addr_nxt    = q_head.addr;
          rd_addr_nxt = q_head.src;
          cnt_nxt     = q_head.moves;
          pend_nxt    = 1'b0;
          word_nxt    = q_head.word;
          count_nxt   = q_head.count;
          status_nxt  = q_head.status;
          rd_word_nxt = '0;
          unique case (q_head.op)
            alist_pkg::OP_WRITE:  state_nxt = S_WRITE;
            alist_pkg::OP_READ:   state_nxt = S_READ;
            alist_pkg::OP_INSERT: state_nxt = (q_head.moves == '0) ? S_WRITE : S_SHIFT;
            alist_pkg::OP_REMOVE: state_nxt = (q_head.moves == '0) ? S_DONE : S_SHIFT;
            default:              state_nxt = S_DONE;
          endcase
        end
      end
      S_WRITE: begin
        ram_we    = 1'b1;
        state_nxt = S_DONE;
      end
      S_READ: begin
        ram_re    = 1'b1;
        state_nxt = S_RDATA;
      end
      S_RDATA: begin
        rd_word_nxt = ram_rdata;
        state_nxt   = S_DONE;
      end
      S_SHIFT: begin
        // read one entry per cycle, write it one place over on the next
        if (pend_r) begin
          ram_we    = 1'b1;
          ram_waddr = wr_addr_r;
          ram_wdata = ram_rdata;
        end
        if (cnt_r != '0) begin
          ram_re    = 1'b1;
          ram_raddr = rd_addr_r;
          pend_nxt  = 1'b1;
          cnt_nxt   = cnt_r - alist_pkg::FILL_W'(1);
          if (is_insert) begin
            wr_addr_nxt = rd_addr_r + alist_pkg::ADDR_W'(1);
            rd_addr_nxt = rd_addr_r - alist_pkg::ADDR_W'(1);
          end else begin
            wr_addr_nxt = rd_addr_r - alist_pkg::ADDR_W'(1);
            rd_addr_nxt = rd_addr_r + alist_pkg::ADDR_W'(1);
          end
        end else begin
          pend_nxt  = 1'b0;
          state_nxt = is_insert ? S_WRITE : S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_word_nxt   = rd_word_r;
          out_count_nxt  = count_r;
          out_status_nxt = status_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    addr_r       <= addr_nxt;
    rd_addr_r    <= rd_addr_nxt;
    wr_addr_r    <= wr_addr_nxt;
    cnt_r        <= cnt_nxt;
    word_r       <= word_nxt;
    count_r      <= count_nxt;
    status_r     <= status_nxt;
    rd_word_r    <= rd_word_nxt;
    out_word_r   <= out_word_nxt;
    out_count_r  <= out_count_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_rsp.valid    = out_valid_r;
  assign out_rsp.word_out = $signed(out_word_r);
  assign out_rsp.count    = out_count_r;
  assign out_rsp.status   = out_status_r;

endmodule

@@ rtl/core/array_list_engine_top.sv @@
// Path from request to result: job queue, back end idle, then WRITE for push, set and an
// insert at the end, READ and RDATA for get, the one-per-cycle RAM shift (then WRITE for
// an insert) when entries move, then DONE, which waits for a free result register; clear,
// spare kinds, rejected requests and removing the last entry go from idle straight to DONE.
// The back end serves one request at a time; the front end can queue two meanwhile.
// Reset (synchronous, active low) empties the list and queue; the RAM needs no clearing.
`timescale 1ns / 1ps

module array_list_engine_top (
  input  logic         clk,
  input  logic         rst_n,
  alist_req_if.sink    in_req,
  alist_rsp_if.source  out_rsp
);

  logic            q_push;
  logic            q_full;
  logic            q_pop;
  logic            q_empty;
  alist_pkg::job_t q_job;
  alist_pkg::job_t q_head;

  alist_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (in_req),
    .q_full (q_full),
    .q_push (q_push),
    .q_job  (q_job)
  );

  alist_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (q_job),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head     (q_head)
  );

  alist_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .out_rsp (out_rsp)
  );

endmodule

@@ rtl/core/alist_checker.sv @@
// Port-level checks on the array list engine, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"

module alist_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [alist_pkg::WORD_W-1:0] out_word_out,
  input logic [alist_pkg::FILL_W-1:0]        out_count,
  input logic [alist_pkg::STATUS_W-1:0]      out_status
);

  `AST_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  `AST_IMPLY(a_full_count, out_valid && out_status == alist_pkg::ST_FULL, out_count == alist_pkg::FILL_W'(alist_pkg::DEPTH))
  `AST_IMPLY(a_range_zero, out_valid && out_status == alist_pkg::ST_RANGE, out_word_out == '0)
  `AST_NEXT_ALWAYS(a_reset_idle, !rst_n, !out_valid)

endmodule

bind array_list_engine_top alist_checker u_alist_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_rsp.valid),
  .out_ready    (out_rsp.ready),
  .out_word_out (out_rsp.word_out),
  .out_count    (out_rsp.count),
  .out_status   (out_rsp.status)
);

@@ verif/testbench.sv @@
// Self-checking testbench for the array list engine: directed and random list traffic
`timescale 1ns / 1ps

module testbench;
  import alist_pkg::*;

  typedef logic signed [POS_W-1:0] pos_t;

  // Kind codes the block must treat as no-ops
  localparam kind_t KIND_SPARE_6 = 3'd6;
  localparam kind_t KIND_SPARE_7 = 3'd7;

  localparam int RANDOM_ITEMS = 1025;
  localparam int FILL_ROOM    = 450;
  localparam int IDLE_PCT     = 35;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 300;
  localparam int CYCLE_LIMIT  = 1500000;

  typedef enum {MIX_GROW, MIX_SHRINK, MIX_MIXED, MIX_FILL} mix_t;

  typedef struct packed {
    word_t   word;
    fill_t   count;
    status_t status;
  } list_result_t;

  // Mirror of the list contents; predicts one result per accepted request
  class list_mirror;
    word_t        cells [DEPTH];
    int           fill;
    list_result_t expected_q [$];
    int unsigned  mismatches;
    int unsigned  checked;

    function new();
      fill       = 0;
      mismatches = 0;
      checked    = 0;
    endfunction

    function void apply_request(kind_t kind, pos_t pos, word_t word);
      list_result_t r;
      int p;
      int at;
      p        = pos;
      r.word   = '0;
      r.status = ST_DONE;
      case (kind)
        KIND_PUSH: begin
          if (fill >= DEPTH) begin
            r.status = ST_FULL;
          end else begin
            cells[fill] = word;
            fill++;
          end
        end
        KIND_INSERT: begin
          if (fill >= DEPTH) begin
            r.status = ST_FULL;
          end else begin
            // index is clamped into 0..fill
            at = (p < 0) ? 0 : ((p > fill) ? fill : p);
            for (int j = fill; j > at; j--) cells[j] = cells[j-1];
            cells[at] = word;
            fill++;
          end
        end
        KIND_REMOVE: begin
          if (p < 0 || p >= fill) begin
            r.status = ST_RANGE;
          end else begin
            for (int j = p; j + 1 < fill; j++) cells[j] = cells[j+1];
            fill--;
          end
        end
        KIND_SET: begin
          if (p < 0 || p >= fill) r.status = ST_RANGE;
          else cells[p] = word;
        end
        KIND_GET: begin
          if (p < 0 || p >= fill) r.status = ST_RANGE;
          else r.word = cells[p];
        end
        KIND_CLEAR: begin
          fill = 0;
        end
        default: begin
        end
      endcase
      r.count = fill_t'(fill);
      expected_q.push_back(r);
    endfunction

    function void check_result(word_t word, fill_t count, status_t status);
      list_result_t e;
      checked++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d with no request pending: word %h count %0d status %0d",
                   checked, word, count, status);
        return;
      end
      e = expected_q.pop_front();
      if (e.word !== word || e.count !== count || e.status !== status) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d mismatch: expected word %h count %0d status %0d,",
                   checked, e.word, e.count, e.status,
                   " got word %h count %0d status %0d", word, count, status);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function bit failed();
      return mismatches != 0 || expected_q.size() != 0;
    endfunction
  endclass

  logic clk;
  logic rst_n;

  alist_req_if req_if ();
  alist_rsp_if rsp_if ();

  array_list_engine_top DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_if),
    .out_rsp (rsp_if)
  );

  list_mirror mirror;
  int         requests_sent;
  int         results_seen;
  int         cycle_count;
  int         hold_left;
  bit         hold_done;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic send_request(input kind_t kind, input pos_t pos, input word_t word);
    // no idling in the quiet stretch
    while (!(requests_sent >= 400 && requests_sent < 600) &&
           $urandom_range(0, 99) < IDLE_PCT) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid    <= 1'b1;
    req_if.kind     <= kind;
    req_if.position <= pos;
    req_if.word_in  <= word;
    do @(posedge clk); while (!req_if.ready);
    mirror.apply_request(kind, pos, word);
    requests_sent++;
  endtask

  function automatic word_t pick_word();
    case ($urandom_range(0, 19))
      0:       return 32'h7fffffff;
      1:       return 32'h80000000;
      2:       return 32'h00000000;
      3:       return 32'hffffffff;
      default: return $urandom;
    endcase
  endfunction

  // Mostly in range, some edges, some anywhere in the 16-bit space
  function automatic pos_t pick_position(kind_t kind);
    int span;
    int r;
    span = (kind == KIND_INSERT) ? mirror.fill : mirror.fill - 1;
    r    = $urandom_range(0, 99);
    if (r < 8) return pos_t'($urandom);
    if (r < 16) begin
      case ($urandom_range(0, 2))
        0:       return pos_t'(-1);
        1:       return pos_t'(span + 1);
        default: return pos_t'(0);
      endcase
    end
    if (span < 0) return pos_t'(0);
    return pos_t'($urandom_range(0, span));
  endfunction

  function automatic kind_t pick_kind(mix_t mix);
    int r;
    r = $urandom_range(0, 99);
    case (mix)
      MIX_GROW: begin
        if (r < 50) return KIND_PUSH;
        if (r < 75) return KIND_INSERT;
        if (r < 85) return KIND_GET;
        if (r < 95) return KIND_SET;
        return KIND_REMOVE;
      end
      MIX_SHRINK: begin
        if (r < 45) return KIND_REMOVE;
        if (r < 65) return KIND_GET;
        if (r < 80) return KIND_SET;
        if (r < 90) return KIND_PUSH;
        return KIND_INSERT;
      end
      MIX_FILL: begin
        if (r < 35) return KIND_PUSH;
        if (r < 70) return KIND_INSERT;
        if (r < 85) return KIND_GET;
        return KIND_SET;
      end
      default: begin
        if (r < 20) return KIND_PUSH;
        if (r < 38) return KIND_INSERT;
        if (r < 56) return KIND_REMOVE;
        if (r < 70) return KIND_SET;
        if (r < 94) return KIND_GET;
        if (r < 97) return KIND_CLEAR;
        if (r < 99) return KIND_SPARE_6;
        return KIND_SPARE_7;
      end
    endcase
  endfunction

  task automatic send_random(input mix_t mix);
    kind_t kind;
    kind = pick_kind(mix);
    send_request(kind, pick_position(kind), pick_word());
  endtask

  task automatic run_directed();
    send_request(KIND_GET,     pos_t'(0),  32'h00000000);
    send_request(KIND_REMOVE,  pos_t'(0),  32'h00000000);
    send_request(KIND_SET,     pos_t'(0),  32'h13579bdf);
    send_request(KIND_PUSH,    pos_t'(0),  32'h7fffffff);
    send_request(KIND_PUSH,    pos_t'(0),  32'h80000000);
    send_request(KIND_INSERT,  16'sh8000,  32'hffffffff);
    send_request(KIND_INSERT,  16'sh7fff,  32'h00000000);
    send_request(KIND_INSERT,  pos_t'(1),  32'h55555555);
    send_request(KIND_GET,     pos_t'(0),  32'h00000000);
    send_request(KIND_GET,     pos_t'(4),  32'h00000000);
    send_request(KIND_GET,     pos_t'(-1), 32'h00000000);
    send_request(KIND_GET,     pos_t'(5),  32'h00000000);
    send_request(KIND_GET,     16'sh7fff,  32'h00000000);
    send_request(KIND_SET,     pos_t'(2),  32'haaaaaaaa);
    send_request(KIND_SET,     16'sh8000,  32'h12345678);
    send_request(KIND_SET,     pos_t'(5),  32'h12345678);
    send_request(KIND_REMOVE,  pos_t'(0),  32'hffffffff);
    send_request(KIND_REMOVE,  pos_t'(-1), 32'h00000000);
    send_request(KIND_REMOVE,  pos_t'(4),  32'h00000000);
    send_request(KIND_REMOVE,  pos_t'(3),  32'h00000000);
    send_request(KIND_SPARE_6, 16'sh7fff,  32'hffffffff);
    send_request(KIND_SPARE_7, 16'sh8000,  32'h80000000);
    send_request(KIND_CLEAR,   pos_t'(0),  32'h00000000);
    send_request(KIND_GET,     pos_t'(0),  32'h00000000);
    send_request(KIND_PUSH,    pos_t'(0),  32'h12345678);
  endtask

  task automatic run_random();
    int   seg;
    int   start;
    int   left;
    int   n;
    mix_t mix;
    seg   = 0;
    start = requests_sent;
    while (requests_sent - start < RANDOM_ITEMS) begin
      left = RANDOM_ITEMS - (requests_sent - start);
      // a fill segment runs a few hundred requests, so only start one with room left
      if (left > FILL_ROOM && (seg == 1 || $urandom_range(0, 9) == 0)) mix = MIX_FILL;
      else mix = mix_t'($urandom_range(0, 2));
      if (mix == MIX_FILL) begin
        // grow to capacity, then hit the full list
        while (mirror.fill < DEPTH) send_random(MIX_GROW);
        repeat (12) send_random(MIX_FILL);
      end else begin
        n = $urandom_range(30, 80);
        if (n > left) n = left;
        repeat (n) send_random(mix);
      end
      seg++;
    end
  endtask

  // Result side: random stalls, one quiet stretch and one long hold-off
  initial begin
    rsp_if.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      @(posedge clk);
      if (rsp_if.valid && rsp_if.ready) begin
        mirror.check_result(rsp_if.word_out, rsp_if.count, rsp_if.status);
        results_seen++;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else if (!hold_done && results_seen >= 700) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= (results_seen >= 400 && results_seen < 600) ||
                        ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  initial begin
    mirror          = new();
    requests_sent   = 0;
    results_seen    = 0;
    cycle_count     = 0;
    hold_left       = 0;
    hold_done       = 1'b0;
    rst_n           <= 1'b0;
    req_if.valid    <= 1'b0;
    req_if.kind     <= KIND_PUSH;
    req_if.position <= '0;
    req_if.word_in  <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();
    run_random();
    req_if.valid <= 1'b0;

    while (mirror.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mirror.failed()) begin
      $display("Regression FAIL");
    end else begin
      $display("Regression PASS");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/alist_pkg.sv
rtl/core/alist_if.sv
rtl/core/alist_ram.sv
rtl/core/alist_front.sv
rtl/core/alist_queue.sv
rtl/core/alist_back.sv
rtl/core/array_list_engine_top.sv
rtl/core/alist_checker.sv
verif/testbench.sv
